[rtl/unsigned_divider_64_macros.svh]
// assertion macros shared by the unsigned divider checker
// no dependencies; take in with `include where assertions are written
`ifndef UNSIGNED_DIVIDER_64_MACROS_SVH
`define UNSIGNED_DIVIDER_64_MACROS_SVH

// a stalled signal must hold its value into the next cycle
`define UD64_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> $stable(sig)) \
        else $error("ud64: signal changed while stalled");

// a condition must imply a result in the same cycle
`define UD64_ASSERT_IMPL(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (res)) \
        else $error("ud64: implication failed");

`endif

[rtl/ud64_pkg.sv]
// types and constants for the unsigned divider
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package ud64_pkg;

    localparam int unsigned FIELD_W = 64;
    localparam int unsigned TDATA_W = 2 * FIELD_W;

    typedef logic [FIELD_W-1:0] t_word;
    typedef logic [TDATA_W-1:0] t_tdata;

endpackage

[rtl/unsigned_divider_64.sv]
// restoring unsigned divider, one quotient bit per pipeline stage
// WIDTH stages; the result leaves from the registers of the last stage
// throughput: one operand pair per cycle; the whole pipe stalls only while a
// finished result waits at the output and the downstream side is not ready
// reset (synchronous, active low) clears the stage valid bits only
// zero divisor gives quotient zero and remainder equal to the dividend
`timescale 1ns / 1ps

module unsigned_divider_64 #(
    parameter int unsigned WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // tdata: dividend [63:0], divisor [127:64]
    input  ud64_pkg::t_tdata   i_s_axis_tdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // tdata: quotient [63:0], remainder [127:64]
    output ud64_pkg::t_tdata   o_m_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready
);

    localparam int unsigned FW = ud64_pkg::FIELD_W;

    logic             r_valid [WIDTH];
    logic [WIDTH-1:0] r_rem   [WIDTH];
    logic [WIDTH-1:0] r_nq    [WIDTH];   // remaining dividend bits, quotient shifts in low
    logic [WIDTH-1:0] r_den   [WIDTH];

    logic [WIDTH-1:0] n_rem   [WIDTH];
    logic [WIDTH-1:0] n_nq    [WIDTH];

    logic             w_advance;
    logic [WIDTH-1:0] w_num_in;
    logic [WIDTH-1:0] w_den_in;
    logic [WIDTH-1:0] w_quo;

    assign w_advance       = !r_valid[WIDTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_advance;

    // operands cut to the datapath width
    assign w_num_in = i_s_axis_tdata[WIDTH-1:0];
    assign w_den_in = i_s_axis_tdata[FW +: WIDTH];

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        logic [WIDTH-1:0] w_src_rem;
        logic [WIDTH-1:0] w_src_nq;
        logic [WIDTH-1:0] w_src_den;
        logic             w_src_vld;
        logic [WIDTH-1:0] w_shift;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_src_rem = '0;
            assign w_src_nq  = w_num_in;
            assign w_src_den = w_den_in;
            assign w_src_vld = i_s_axis_tvalid;
        end else begin : g_next
            assign w_src_rem = r_rem[k-1];
            assign w_src_nq  = r_nq[k-1];
            assign w_src_den = r_den[k-1];
            assign w_src_vld = r_valid[k-1];
        end

        // partial remainder never reaches the top bit before its shift
        assign w_shift  = {w_src_rem[WIDTH-2:0], w_src_nq[WIDTH-1]};
        assign w_ge     = (w_shift >= w_src_den);
        assign n_rem[k] = w_ge ? (w_shift - w_src_den) : w_shift;
        assign n_nq[k]  = {w_src_nq[WIDTH-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_advance) begin
                r_valid[k] <= w_src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= w_src_den;
            end
        end
    end

    // with a zero divisor every step sets its bit, so the quotient is forced to zero
    assign w_quo = (r_den[WIDTH-1] == '0) ? '0 : r_nq[WIDTH-1];

    assign o_m_axis_tvalid = r_valid[WIDTH-1];
    assign o_m_axis_tdata  = {ud64_pkg::t_word'(r_rem[WIDTH-1]), ud64_pkg::t_word'(w_quo)};

endmodule

[rtl/ud64_checker.sv]
// port-level checker for the unsigned divider, bound to the top level
// depends on ud64_pkg and unsigned_divider_64_macros.svh
`timescale 1ns / 1ps
`include "unsigned_divider_64_macros.svh"

module ud64_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input ud64_pkg::t_tdata i_s_axis_tdata,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input ud64_pkg::t_tdata o_m_axis_tdata,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready
);

    // a result offered and not taken stays offered
    `UD64_ASSERT_HOLD(a_out_valid_hold, i_clk, i_rst_n, o_m_axis_tvalid, i_m_axis_tready, o_m_axis_tvalid)

    // and keeps its data
    `UD64_ASSERT_HOLD(a_out_data_hold, i_clk, i_rst_n, o_m_axis_tvalid, i_m_axis_tready, o_m_axis_tdata)

    // input side is held off only by a waiting result
    `UD64_ASSERT_IMPL(a_ready_rule, i_clk, i_rst_n, 1'b1, o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))

    // nothing comes out in the first cycle after reset
    `UD64_ASSERT_IMPL(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_m_axis_tvalid)

endmodule

bind unsigned_divider_64 ud64_checker u_ud64_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

[sim/testbench.sv]
// testbench for the restoring unsigned divider: directed and random operand pairs,
// results checked against a bit-serial divide held in a small scoreboard class
// depends on ud64_pkg and unsigned_divider_64
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned FIELD_W = ud64_pkg::FIELD_W;
    localparam int unsigned TDATA_W = ud64_pkg::TDATA_W;
    localparam int unsigned DIV_LATENCY = 64;
    localparam int unsigned STUCK_LIMIT = 4000;
    localparam int unsigned RANDOM_PAIRS = 880;
    localparam int unsigned CALM_PAIRS = 100;
    localparam ud64_pkg::t_word ALL_ONES = {FIELD_W{1'b1}};
    localparam ud64_pkg::t_word TOP_BIT = ud64_pkg::t_word'(1) << (FIELD_W - 1);

    // expected quotient and remainder for every operand pair taken in, oldest first
    class div_results;
        ud64_pkg::t_word quo_due[$];
        ud64_pkg::t_word rem_due[$];
        int              errors = 0;

        task report(string what, ud64_pkg::t_word got, ud64_pkg::t_word want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        // shift-and-subtract, one quotient bit per step from the top down
        function void divide(input ud64_pkg::t_word dividend, input ud64_pkg::t_word divisor,
                             output ud64_pkg::t_word quo, output ud64_pkg::t_word rem);
            logic [FIELD_W:0] part;
            quo = '0;
            part = '0;
            if (divisor == '0) begin
                rem = dividend;
                return;
            end
            for (int i = FIELD_W - 1; i >= 0; i--) begin
                part = {part[FIELD_W-1:0], dividend[i]};
                if (part >= {1'b0, divisor}) begin
                    part = part - {1'b0, divisor};
                    quo[i] = 1'b1;
                end
            end
            rem = part[FIELD_W-1:0];
        endfunction

        function void note_operands(ud64_pkg::t_word dividend, ud64_pkg::t_word divisor);
            ud64_pkg::t_word q;
            ud64_pkg::t_word r;
            divide(dividend, divisor, q, r);
            quo_due.push_back(q);
            rem_due.push_back(r);
        endfunction

        task check_result(ud64_pkg::t_word quo, ud64_pkg::t_word rem);
            ud64_pkg::t_word q;
            ud64_pkg::t_word r;
            if (quo_due.size() == 0) begin
                report("result with nothing due, quotient", quo, '0);
                return;
            end
            q = quo_due.pop_front();
            r = rem_due.pop_front();
            if (quo !== q) report("quotient", quo, q);
            if (rem !== r) report("remainder", rem, r);
        endtask

        function int pending();
            return quo_due.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    ud64_pkg::t_tdata i_s_axis_tdata;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    ud64_pkg::t_tdata o_m_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;

    div_results sb;
    int         src_gap_pct = 20;
    int         sink_stall_pct = 20;
    int         sink_stall_left = 0;
    int         stuck = 0;

    unsigned_divider_64 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        sb = new;
    end

    // downstream side: ready, with random stall bursts
    always @(posedge i_clk) begin
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            sink_stall_left = $urandom_range(1, 7) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // transfer monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_operands(i_s_axis_tdata[FIELD_W-1:0], i_s_axis_tdata[TDATA_W-1:FIELD_W]);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata[FIELD_W-1:0], o_m_axis_tdata[TDATA_W-1:FIELD_W]);
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck = 0;
        end else begin
            stuck++;
        end
        if (stuck >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic ud64_pkg::t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // random value of a random bit length, so small operands turn up often
    function automatic ud64_pkg::t_word rand_short();
        int n;
        n = $urandom_range(1, FIELD_W);
        return rand_word() >> (FIELD_W - n);
    endfunction

    task automatic send_pair(input ud64_pkg::t_word dividend, input ud64_pkg::t_word divisor);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tdata <= {divisor, dividend};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    task automatic send_random_pair();
        ud64_pkg::t_word a;
        ud64_pkg::t_word b;
        a = rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2: b = rand_word();
            3, 4:    b = rand_short();
            5, 6: begin
                a = rand_short();
                b = rand_short();
            end
            7:       b = '0;
            // divisor close to the dividend, either side
            8:       b = a + ud64_pkg::t_word'($urandom_range(0, 6)) - 3;
            default: begin
                // dividend is the divisor times a random factor, cut to the word width, plus 0 to 3
                b = rand_short() >> $urandom_range(0, 32);
                if (b == '0) b = 1;
                a = b * (rand_word() >> $urandom_range(0, 63))
                    + ud64_pkg::t_word'($urandom_range(0, 3));
            end
        endcase
        send_pair(a, b);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_m_axis_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner operands
        send_pair('0, '0);
        send_pair('0, 1);
        send_pair(ALL_ONES, '0);
        send_pair(ALL_ONES, 1);
        send_pair(ALL_ONES, ALL_ONES);
        send_pair(1, ALL_ONES);
        send_pair(ALL_ONES - 1, ALL_ONES);
        send_pair(ALL_ONES, ALL_ONES - 1);
        send_pair(TOP_BIT, 2);
        send_pair(TOP_BIT, TOP_BIT);
        send_pair(TOP_BIT, TOP_BIT + 1);
        send_pair(TOP_BIT - 1, TOP_BIT);
        send_pair(ALL_ONES, TOP_BIT);
        send_pair(5, '0);
        send_pair(64'd123456789, 64'd1000);
        send_pair(rand_word(), '0);
        send_pair(rand_word(), 1);
        send_pair({FIELD_W/2{2'b10}}, {FIELD_W/2{2'b01}});
        send_pair({FIELD_W/2{2'b01}}, {FIELD_W/2{2'b10}});
        send_pair(ALL_ONES, ud64_pkg::t_word'(1) << 32);
        send_pair(ALL_ONES, 3);
        send_pair(7, rand_word() | TOP_BIT);
        begin
            ud64_pkg::t_word same;
            same = rand_word();
            send_pair(same, same);
        end

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            if (i % 100 == 0 && i < RANDOM_PAIRS - CALM_PAIRS) begin
                src_gap_pct = 10 * $urandom_range(0, 3);
                sink_stall_pct = 10 * $urandom_range(0, 3);
            end
            if (i == RANDOM_PAIRS - CALM_PAIRS) begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            // let the pipe drain completely once before carrying on
            if (i == RANDOM_PAIRS / 2) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            send_random_pair();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        // catch any stray result after the last one due
        repeat (DIV_LATENCY + 16) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[unsigned_divider_64.f]
+incdir+rtl
rtl/ud64_pkg.sv
rtl/unsigned_divider_64.sv
rtl/ud64_checker.sv
sim/testbench.sv
